### sv/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and helpers for the PID core with back-calculation
// anti-windup: widths, reset values, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int GAIN_W     = 32;
  localparam int INTEG_W    = 40;
  localparam int OUT_W      = 32;
  localparam int WIDE_W     = 64;
  localparam int LIMB_W     = 32;
  localparam int MULB_W     = LIMB_W + 1;
  localparam int PROD_W     = GAIN_W + MULB_W;
  localparam int ACC_W      = WIDE_W + GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [MULB_W-1:0] mulb_t;
  typedef logic signed [GAIN_W-1:0] gain_t;

  localparam wide_t WIDE_LIM  = 64'sh4000_0000_0000_0000;
  localparam wide_t INT40_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam wide_t INT40_MIN = 64'shFFFF_FF80_0000_0000;

  localparam logic signed [INTEG_W-1:0] INTEG_MIN_RST = 40'sh80_0000_0000;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX_RST = 40'sh7F_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0]   OUT_MIN_RST   = 32'sh8000_0000;
  localparam logic signed [OUT_W-1:0]   OUT_MAX_RST   = 32'sh7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_WINDUP_GAIN,
    CFG_INTEGRAL_MIN,
    CFG_INTEGRAL_MAX,
    CFG_OUTPUT_MIN,
    CFG_OUTPUT_MAX
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SHIFT_ADD
  } acc_op_t;

  typedef struct packed {
    acc_op_t op;
    gain_t   a;
    mulb_t   b;
  } mac_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INTEG, S_DTERM, S_IHI, S_ILO, S_IACC, S_SUM, S_CLIP, S_DIFF,
    S_C1HI, S_C1LO, S_C1ACC, S_C1SAT, S_CRHI, S_CRLO, S_CRACC, S_CRSAT,
    S_UPD, S_DONE
  } state_t;

  // low test first, so inverted bounds give the low bound below it, else the high bound
  function automatic wide_t clamp_wide(wide_t x, wide_t lo, wide_t hi);
    if (x < lo) return lo;
    if (hi < x) return hi;
    return x;
  endfunction

  function automatic wide_t sat_wide(acc_t x);
    if (x > acc_t'(WIDE_LIM)) return WIDE_LIM;
    if (x < -acc_t'(WIDE_LIM)) return -WIDE_LIM;
    return x[WIDE_W-1:0];
  endfunction

  function automatic mulb_t hi_limb(wide_t v);
    return {v[WIDE_W-1], v[WIDE_W-1:LIMB_W]};
  endfunction

  function automatic mulb_t lo_limb(wide_t v);
    return {1'b0, v[LIMB_W-1:0]};
  endfunction

endpackage

### sv/pid_controller_anti_windup_core.sv
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_core
// Fixed-point PID controller with back-calculation anti-windup, built around
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries a setpoint and a measured sample.
// The block takes one item at a time: in_ready is low from a transfer until
// the sequencer returns to idle, and drive is loaded into the output register
// as it leaves its done state. The single 32x33 multiplier forms the P and D
// products in one pass each and the integral term and both back-calculation
// products in two limb passes each, with clamp and saturate steps in between.
// A finished result waits in its own register, so the next item can be taken
// while drive is still unclaimed; the block stalls only if a second result is
// done before the first one is taken. Gains are Q16.16, the integral Q24.16,
// drive Q16.16. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup_core #(
  parameter int SAMPLE_BITS = pidaw_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          setpoint,
  input  logic signed [SAMPLE_BITS-1:0]          measured,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pidaw_pkg::OUT_W-1:0]     drive,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DERR_W = SAMPLE_BITS + 2;

  // configuration registers
  pidaw_pkg::gain_t                      prop_gain, integ_gain, deriv_gain, windup_gain;
  logic signed [pidaw_pkg::INTEG_W-1:0]  integral_min, integral_max;
  logic signed [pidaw_pkg::OUT_W-1:0]    output_min, output_max;

  // loop state
  logic signed [pidaw_pkg::INTEG_W-1:0]  integral;
  logic signed [ERR_W-1:0]               last_err;

  // per-item working registers
  logic signed [ERR_W-1:0]               err_q;
  logic signed [DERR_W-1:0]              derr_q;
  pidaw_pkg::wide_t                      pd_sum;     // P + D terms
  pidaw_pkg::wide_t                      unclipped;
  logic signed [pidaw_pkg::OUT_W-1:0]    clip_q;
  pidaw_pkg::wide_t                      diff_q;     // unclipped - clipped
  pidaw_pkg::wide_t                      scaled;     // c1, then the correction

  pidaw_pkg::state_t   state, state_next;
  pidaw_pkg::mac_cmd_t cmd;
  pidaw_pkg::acc_t     acc;
  pidaw_pkg::acc_t     acc_sh;

  logic signed [ERR_W-1:0]  err_in;
  logic signed [DERR_W-1:0] derr_in;
  pidaw_pkg::wide_t         integ_add, out_clamp, integ_fix, acc_sat;
  logic                     in_xfer, out_load;

  assign err_in  = ERR_W'(setpoint) - ERR_W'(measured);
  assign derr_in = DERR_W'(err_in) - DERR_W'(last_err);
  assign in_xfer = in_valid && in_ready;
  assign out_load = (state == pidaw_pkg::S_DONE) && (!out_valid || out_ready);

  // floor shift of the accumulated product, then the +-2^62 limit
  assign acc_sh  = acc >>> FRAC_BITS;
  assign acc_sat = pidaw_pkg::sat_wide(acc_sh);

  assign integ_add = pidaw_pkg::clamp_wide(
      pidaw_pkg::wide_t'(integral) + (pidaw_pkg::wide_t'(err_q) <<< FRAC_BITS),
      pidaw_pkg::wide_t'(integral_min), pidaw_pkg::wide_t'(integral_max));
  assign out_clamp = pidaw_pkg::clamp_wide(unclipped,
      pidaw_pkg::wide_t'(output_min), pidaw_pkg::wide_t'(output_max));
  assign integ_fix = pidaw_pkg::clamp_wide(pidaw_pkg::wide_t'(integral) - scaled,
      pidaw_pkg::INT40_MIN, pidaw_pkg::INT40_MAX);

  pidaw_mac u_mac (
    .clk (clk),
    .cmd (cmd),
    .acc (acc)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      windup_gain  <= '0;
      integral_min <= pidaw_pkg::INTEG_MIN_RST;
      integral_max <= pidaw_pkg::INTEG_MAX_RST;
      output_min   <= pidaw_pkg::OUT_MIN_RST;
      output_max   <= pidaw_pkg::OUT_MAX_RST;
    end else if (cfg_write) begin
      case (pidaw_pkg::cfg_idx_t'(cfg_index))
        pidaw_pkg::CFG_PROP_GAIN:    prop_gain    <= cfg_data[pidaw_pkg::GAIN_W-1:0];
        pidaw_pkg::CFG_INTEG_GAIN:   integ_gain   <= cfg_data[pidaw_pkg::GAIN_W-1:0];
        pidaw_pkg::CFG_DERIV_GAIN:   deriv_gain   <= cfg_data[pidaw_pkg::GAIN_W-1:0];
        pidaw_pkg::CFG_WINDUP_GAIN:  windup_gain  <= cfg_data[pidaw_pkg::GAIN_W-1:0];
        pidaw_pkg::CFG_INTEGRAL_MIN: integral_min <= cfg_data[pidaw_pkg::INTEG_W-1:0];
        pidaw_pkg::CFG_INTEGRAL_MAX: integral_max <= cfg_data[pidaw_pkg::INTEG_W-1:0];
        pidaw_pkg::CFG_OUTPUT_MIN:   output_min   <= cfg_data[pidaw_pkg::OUT_W-1:0];
        pidaw_pkg::CFG_OUTPUT_MAX:   output_max   <= cfg_data[pidaw_pkg::OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidaw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and accumulator op.
  // cmd.op applies to the product issued one state earlier.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = pidaw_pkg::ACC_HOLD;
    cmd.a      = integ_gain;
    cmd.b      = pidaw_pkg::lo_limb(scaled);
    case (state)
      pidaw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = pidaw_pkg::S_INTEG;
      end
      pidaw_pkg::S_INTEG: begin
        cmd.a = prop_gain;
        cmd.b = pidaw_pkg::mulb_t'(err_q);
        state_next = pidaw_pkg::S_DTERM;
      end
      pidaw_pkg::S_DTERM: begin
        cmd.op = pidaw_pkg::ACC_LOAD;
        cmd.a  = deriv_gain;
        cmd.b  = pidaw_pkg::mulb_t'(derr_q);
        state_next = pidaw_pkg::S_IHI;
      end
      pidaw_pkg::S_IHI: begin
        cmd.op = pidaw_pkg::ACC_ADD;
        cmd.b  = pidaw_pkg::hi_limb(pidaw_pkg::wide_t'(integral));
        state_next = pidaw_pkg::S_ILO;
      end
      pidaw_pkg::S_ILO: begin
        cmd.op = pidaw_pkg::ACC_LOAD;
        cmd.b  = pidaw_pkg::lo_limb(pidaw_pkg::wide_t'(integral));
        state_next = pidaw_pkg::S_IACC;
      end
      pidaw_pkg::S_IACC: begin
        cmd.op = pidaw_pkg::ACC_SHIFT_ADD;
        state_next = pidaw_pkg::S_SUM;
      end
      pidaw_pkg::S_SUM:  state_next = pidaw_pkg::S_CLIP;
      pidaw_pkg::S_CLIP: state_next = pidaw_pkg::S_DIFF;
      pidaw_pkg::S_DIFF: state_next = pidaw_pkg::S_C1HI;
      pidaw_pkg::S_C1HI: begin
        cmd.a = windup_gain;
        cmd.b = pidaw_pkg::hi_limb(diff_q);
        state_next = pidaw_pkg::S_C1LO;
      end
      pidaw_pkg::S_C1LO: begin
        cmd.op = pidaw_pkg::ACC_LOAD;
        cmd.a  = windup_gain;
        cmd.b  = pidaw_pkg::lo_limb(diff_q);
        state_next = pidaw_pkg::S_C1ACC;
      end
      pidaw_pkg::S_C1ACC: begin
        cmd.op = pidaw_pkg::ACC_SHIFT_ADD;
        state_next = pidaw_pkg::S_C1SAT;
      end
      pidaw_pkg::S_C1SAT: state_next = pidaw_pkg::S_CRHI;
      pidaw_pkg::S_CRHI: begin
        cmd.b = pidaw_pkg::hi_limb(scaled);
        state_next = pidaw_pkg::S_CRLO;
      end
      pidaw_pkg::S_CRLO: begin
        cmd.op = pidaw_pkg::ACC_LOAD;
        cmd.b  = pidaw_pkg::lo_limb(scaled);
        state_next = pidaw_pkg::S_CRACC;
      end
      pidaw_pkg::S_CRACC: begin
        cmd.op = pidaw_pkg::ACC_SHIFT_ADD;
        state_next = pidaw_pkg::S_CRSAT;
      end
      pidaw_pkg::S_CRSAT: state_next = pidaw_pkg::S_UPD;
      pidaw_pkg::S_UPD:   state_next = pidaw_pkg::S_DONE;
      pidaw_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = pidaw_pkg::S_IDLE;
      end
      default: state_next = pidaw_pkg::S_IDLE;
    endcase
  end

  // loop state: integral and last error
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      last_err <= '0;
    end else begin
      if (in_xfer) last_err <= err_in;
      if (state == pidaw_pkg::S_INTEG) integral <= integ_add[pidaw_pkg::INTEG_W-1:0];
      if (state == pidaw_pkg::S_UPD)   integral <= integ_fix[pidaw_pkg::INTEG_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_q  <= err_in;
      derr_q <= derr_in;
    end
    case (state)
      pidaw_pkg::S_ILO:   pd_sum    <= acc[pidaw_pkg::WIDE_W-1:0];
      pidaw_pkg::S_SUM:   unclipped <= pd_sum + acc_sh[pidaw_pkg::WIDE_W-1:0];
      pidaw_pkg::S_CLIP:  clip_q    <= out_clamp[pidaw_pkg::OUT_W-1:0];
      pidaw_pkg::S_DIFF:  diff_q    <= unclipped - pidaw_pkg::wide_t'(clip_q);
      pidaw_pkg::S_C1SAT: scaled    <= acc_sat;
      pidaw_pkg::S_CRSAT: scaled    <= acc_sat;
      default: ;
    endcase
  end

  // output register, separate from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) drive <= clip_q;
  end

  // a transfer starts a busy period
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken again right after a transfer");

  // finished item lands in the output register and frees the sequencer
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == pidaw_pkg::S_IDLE))
    else $error("result not loaded on completion");

  // back-calculation products stay within the saturation limit
  a_scaled_limit: assert property (@(posedge clk) disable iff (rst)
    (state == pidaw_pkg::S_CRHI || state == pidaw_pkg::S_UPD) |->
      (scaled <= pidaw_pkg::WIDE_LIM && scaled >= -pidaw_pkg::WIDE_LIM))
    else $error("back-calculation product beyond limit");

  // clamped integral is at least the low bound, or the high bound if inverted
  a_integ_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == pidaw_pkg::S_IHI) |->
      (integral >= integral_min || integral == integral_max))
    else $error("integral outside its clamp");

endmodule

### sv/pidaw_mac.sv
// ----------------------------------------------------------------------------
// pidaw_mac
// Shared multiply-accumulate: one registered 32x33 signed multiplier feeding
// a 96-bit accumulator that loads, adds, or shifts by one limb and adds.
// ----------------------------------------------------------------------------
module pidaw_mac (
  input  logic                clk,
  input  pidaw_pkg::mac_cmd_t cmd,
  output pidaw_pkg::acc_t     acc
);

  pidaw_pkg::prod_t prod;

  always_ff @(posedge clk) begin
    prod <= pidaw_pkg::prod_t'(cmd.a) * pidaw_pkg::prod_t'(cmd.b);
  end

  // op acts on the product issued in the previous cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      pidaw_pkg::ACC_LOAD:      acc <= pidaw_pkg::acc_t'(prod);
      pidaw_pkg::ACC_ADD:       acc <= acc + pidaw_pkg::acc_t'(prod);
      pidaw_pkg::ACC_SHIFT_ADD: acc <= (acc <<< pidaw_pkg::LIMB_W) + pidaw_pkg::acc_t'(prod);
      default:                  acc <= acc;
    endcase
  end

endmodule

### dv/pidaw_drive_checker.sv
// ----------------------------------------------------------------------------
// pidaw_drive_checker
// Watches the config port and both channels of the PID core, predicts drive
// for every accepted sample pair and compares it with each drive transfer.
// ----------------------------------------------------------------------------
module pidaw_drive_checker (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic                                         in_ready,
  input  logic signed [pidaw_pkg::SAMPLE_BITS_DEF-1:0] setpoint,
  input  logic signed [pidaw_pkg::SAMPLE_BITS_DEF-1:0] measured,
  input  logic                                         out_valid,
  input  logic                                         out_ready,
  input  logic signed [pidaw_pkg::OUT_W-1:0]           drive,
  input  logic                                         cfg_write,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]             cfg_data,
  output int                                           failures,
  output int                                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers and controller state
  pidaw_pkg::wide_t kp, ki, kd, kw;
  pidaw_pkg::wide_t integ_lo, integ_hi, out_lo, out_hi;
  pidaw_pkg::wide_t integ, prev_err;

  logic signed [pidaw_pkg::OUT_W-1:0] drive_due[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic pidaw_pkg::wide_t bound(pidaw_pkg::wide_t x, pidaw_pkg::wide_t lo,
                                             pidaw_pkg::wide_t hi);
    if (x < lo) return lo;
    return (hi < x) ? hi : x;
  endfunction

  // exact product, floor shift, saturate to +-2^62
  function automatic pidaw_pkg::wide_t mul_floor_sat(pidaw_pkg::wide_t a,
                                                     pidaw_pkg::wide_t b);
    logic signed [127:0] wa, wb, full, lim;
    wa   = 128'(a);
    wb   = 128'(b);
    lim  = 128'(pidaw_pkg::WIDE_LIM);
    full = (wa * wb) >>> pidaw_pkg::FRAC_BITS_DEF;
    if (full > lim) return pidaw_pkg::WIDE_LIM;
    if (full < -lim) return -pidaw_pkg::WIDE_LIM;
    return full[pidaw_pkg::WIDE_W-1:0];
  endfunction

  function automatic logic signed [pidaw_pkg::OUT_W-1:0] next_drive(
      logic signed [pidaw_pkg::SAMPLE_BITS_DEF-1:0] sp,
      logic signed [pidaw_pkg::SAMPLE_BITS_DEF-1:0] ms);
    pidaw_pkg::wide_t err, p_term, i_term, d_term, raw, held, excess, back1, back2;
    err    = pidaw_pkg::wide_t'(sp) - pidaw_pkg::wide_t'(ms);
    integ  = bound(integ + (err <<< pidaw_pkg::FRAC_BITS_DEF), integ_lo, integ_hi);
    p_term = kp * err;
    i_term = mul_floor_sat(ki, integ);
    d_term = kd * (err - prev_err);
    prev_err = err;
    raw    = p_term + i_term + d_term;
    held   = bound(raw, out_lo, out_hi);
    // back-calculation: bleed the clipped excess out of the integral
    excess = raw - held;
    back1  = mul_floor_sat(excess, kw);
    back2  = mul_floor_sat(back1, ki);
    integ  = bound(integ - back2, pidaw_pkg::INT40_MIN, pidaw_pkg::INT40_MAX);
    return held[pidaw_pkg::OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [pidaw_pkg::OUT_W-1:0] want;
    pidaw_pkg::wide_t g32, g40;
    if (rst) begin
      kp = '0; ki = '0; kd = '0; kw = '0;
      integ_lo = pidaw_pkg::wide_t'(pidaw_pkg::INTEG_MIN_RST);
      integ_hi = pidaw_pkg::wide_t'(pidaw_pkg::INTEG_MAX_RST);
      out_lo   = pidaw_pkg::wide_t'(pidaw_pkg::OUT_MIN_RST);
      out_hi   = pidaw_pkg::wide_t'(pidaw_pkg::OUT_MAX_RST);
      integ    = '0;
      prev_err = '0;
      drive_due.delete();
    end else begin
      if (cfg_write) begin
        g32 = pidaw_pkg::wide_t'($signed(cfg_data[pidaw_pkg::GAIN_W-1:0]));
        g40 = pidaw_pkg::wide_t'($signed(cfg_data[pidaw_pkg::INTEG_W-1:0]));
        case (pidaw_pkg::cfg_idx_t'(cfg_index))
          pidaw_pkg::CFG_PROP_GAIN:    kp       = g32;
          pidaw_pkg::CFG_INTEG_GAIN:   ki       = g32;
          pidaw_pkg::CFG_DERIV_GAIN:   kd       = g32;
          pidaw_pkg::CFG_WINDUP_GAIN:  kw       = g32;
          pidaw_pkg::CFG_INTEGRAL_MIN: integ_lo = g40;
          pidaw_pkg::CFG_INTEGRAL_MAX: integ_hi = g40;
          pidaw_pkg::CFG_OUTPUT_MIN:   out_lo   = g32;
          pidaw_pkg::CFG_OUTPUT_MAX:   out_hi   = g32;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          failures++;
          $display("%0t: drive transfer with nothing expected, actual %0d", $time, drive);
        end else begin
          want = drive_due.pop_front();
          if (drive !== want) begin
            failures++;
            $display("%0t: drive mismatch, expected %0d actual %0d", $time, want, drive);
          end
        end
      end
      if (in_valid && in_ready) drive_due.push_back(next_drive(setpoint, measured));
    end
    pending = drive_due.size();
  end

endmodule

### dv/tb_pid_controller_anti_windup_core.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_anti_windup_core
// Drives sample pairs and register settings into the PID core and leaves all
// prediction and comparison of drive to the checker that sits beside it.
// ----------------------------------------------------------------------------
module tb_pid_controller_anti_windup_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 55;
  localparam logic [31:0] Q_ONE       = 32'h0001_0000;
  localparam int          SW          = pidaw_pkg::SAMPLE_BITS_DEF;
  localparam int          DW          = pidaw_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // sample channel
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [SW-1:0]                setpoint = '0;
  logic signed [SW-1:0]                measured = '0;
  // drive channel
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [pidaw_pkg::OUT_W-1:0]  drive;
  // register port
  logic                                cfg_write = 1'b0;
  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DW-1:0]                       cfg_data  = '0;

  int failures;
  int pending;
  int cycles = 0;

  // idling switches, both cleared for the last phases
  bit in_gaps    = 1'b1;
  bit out_stalls = 1'b1;

  // slowly moving target for closed-loop-like sequences
  logic signed [SW-1:0] track_target = '0;

  pid_controller_anti_windup_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pidaw_drive_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the core hangs or loses a result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random back-pressure bursts on out_ready. Changes only at the
  // falling edge, one assignment per edge.
  initial begin
    forever begin
      @(negedge clk);
      if (out_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // One sample transfer. Called and returns at a falling edge; valid stays
  // high into the next call when no gap is inserted.
  task automatic send_sample(input logic signed [SW-1:0] sp,
                             input logic signed [SW-1:0] ms);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    setpoint <= sp;
    measured <= ms;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input pidaw_pkg::cfg_idx_t idx, input logic [DW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Loads all eight registers once the core has drained. Upper data bits of
  // the 32-bit registers carry noise, which the core must ignore.
  task automatic apply_setting(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] kw,
                               input logic [39:0] ilo, input logic [39:0] ihi,
                               input logic [31:0] olo, input logic [31:0] ohi);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(pidaw_pkg::CFG_PROP_GAIN,    {8'($urandom()), kp});
    write_reg(pidaw_pkg::CFG_INTEG_GAIN,   {8'($urandom()), ki});
    write_reg(pidaw_pkg::CFG_DERIV_GAIN,   {8'($urandom()), kd});
    write_reg(pidaw_pkg::CFG_WINDUP_GAIN,  {8'($urandom()), kw});
    write_reg(pidaw_pkg::CFG_INTEGRAL_MIN, ilo);
    write_reg(pidaw_pkg::CFG_INTEGRAL_MAX, ihi);
    write_reg(pidaw_pkg::CFG_OUTPUT_MIN,   {8'($urandom()), olo});
    write_reg(pidaw_pkg::CFG_OUTPUT_MAX,   {8'($urandom()), ohi});
    cfg_write <= 1'b0;
  endtask

  // often small gains (|g| <= 4.0), sometimes the extremes or anything
  function automatic logic [31:0] pick_gain();
    int mag;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5, 6: begin
        mag = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(0, 1) ? mag : -mag;
      end
      default: return $urandom();
    endcase
  endfunction

  // random value of width w at a random scale, sign-extended to 40 bits
  function automatic logic signed [39:0] scaled_value(int w);
    logic signed [39:0] v;
    v = {8'($urandom()), 32'($urandom())};
    if (w == 32) v = 40'($signed(v[31:0]));
    return v >>> $urandom_range(0, w - 8);
  endfunction

  task automatic random_setting();
    logic signed [39:0] ilo, ihi, olo, ohi, t;
    ilo = scaled_value(40);
    ihi = scaled_value(40);
    // keep bounds ordered most of the time; an inverted pair now and then
    if (ilo > ihi && $urandom_range(0, 7) != 0) begin
      t = ilo; ilo = ihi; ihi = t;
    end
    if ($urandom_range(0, 5) == 0) begin
      ilo = pidaw_pkg::INTEG_MIN_RST;
      ihi = pidaw_pkg::INTEG_MAX_RST;
    end
    olo = scaled_value(32);
    ohi = scaled_value(32);
    if (olo > ohi && $urandom_range(0, 7) != 0) begin
      t = olo; olo = ohi; ohi = t;
    end
    if ($urandom_range(0, 5) == 0) begin
      olo = 40'(pidaw_pkg::OUT_MIN_RST);
      ohi = 40'(pidaw_pkg::OUT_MAX_RST);
    end
    apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  ilo, ihi, olo[31:0], ohi[31:0]);
  endtask

  function automatic logic signed [SW-1:0] extreme_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // Mostly a measurement chasing a slowly moving target, which keeps the
  // integral and the anti-windup path busy; the rest is extremes and noise.
  task automatic pick_sample(output logic signed [SW-1:0] sp,
                             output logic signed [SW-1:0] ms);
    int m, jitter;
    case ($urandom_range(0, 9))
      0: begin
        sp = extreme_sample();
        ms = extreme_sample();
      end
      1, 2: begin
        sp = 16'($urandom());
        ms = 16'($urandom());
      end
      default: begin
        if ($urandom_range(0, 9) == 0) track_target = 16'($urandom());
        jitter = $urandom_range(0, 256);
        m = int'(track_target) + jitter - 128;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        sp = track_target;
        ms = 16'(m);
      end
    endcase
  endtask

  initial begin
    logic signed [SW-1:0] sp, ms;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset gains are zero: drive must stay at zero
    send_sample(16'sd1000, -16'sd1000);
    send_sample(16'sh8000, 16'sh7FFF);

    // moderate gains, output clipped at +-2000.0 so full-scale errors wind up
    apply_setting(Q_ONE, Q_ONE >> 1, Q_ONE >> 2, Q_ONE,
                  -(40'sd1 <<< 36), 40'sd1 <<< 36,
                  -(32'sd2000 <<< 16), 32'sd2000 <<< 16);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd100, 16'sd90);
    send_sample(-16'sd5, 16'sd5);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);

    // inverted bounds on both clamps: values below the min take the min
    apply_setting(Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                  40'sd1 <<< 20, -(40'sd1 <<< 20),
                  32'sd1000 <<< 16, -(32'sd1000 <<< 16));
    send_sample(16'sd10, 16'sd0);
    send_sample(-16'sd10, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd30000, -16'sd30000);
    send_sample(-16'sd30000, 16'sd30000);

    // extreme gains and full-range bounds: wide sum past 32 bits, saturated
    // products, integral driven against its 40-bit limits by back-calculation
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  pidaw_pkg::INTEG_MIN_RST, pidaw_pkg::INTEG_MAX_RST,
                  pidaw_pkg::OUT_MIN_RST, pidaw_pkg::OUT_MAX_RST);
    repeat (3) begin
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
    end
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);

    // random phases, a fresh register setting each, no idling at the end
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 2) begin
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
      end
      random_setting();
      repeat (PHASE_ITEMS) begin
        pick_sample(sp, ms);
        send_sample(sp, ms);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
